@@ design/rans16_pkg.sv @@
package rans16_pkg;

  localparam int STATE_W = 32;
  localparam int WORD_W  = 16;
  localparam int REQ_W   = 2;
  localparam int SYM_W   = 5;
  localparam int FREQ_W  = 8;
  localparam int CUM_W   = 7;
  localparam int KIND_W  = 2;
  localparam int ENTRY_W = FREQ_W + CUM_W;

  localparam logic [STATE_W-1:0] STATE_RESET = 32'd65535;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WORD  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_EMIT
  } enc_state_t;

endpackage

@@ design/rans16_in_if.sv @@
interface rans16_in_if import rans16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SYM_W-1:0]  symbol_index;
  logic [FREQ_W-1:0] load_freq;
  logic [CUM_W-1:0]  load_cum;

  modport source (output valid, req_type, symbol_index, load_freq, load_cum, input ready);
  modport sink   (input valid, req_type, symbol_index, load_freq, load_cum, output ready);
endinterface

@@ design/rans16_out_if.sv @@
interface rans16_out_if import rans16_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  out_kind;
  logic [WORD_W-1:0]  renorm_word;
  logic [WORD_W-1:0]  word_index;
  logic [STATE_W-1:0] final_state;

  modport source (output valid, out_kind, renorm_word, word_index, final_state, input ready);
  modport sink   (input valid, out_kind, renorm_word, word_index, final_state, output ready);
endinterface

@@ design/rans_encoder_16bit_renorm.sv @@
// Channel   Direction  Fields                                             Transaction
// in_chan   sink       req_type, symbol_index, load_freq, load_cum        valid & ready
// out_chan  source     out_kind, renorm_word, word_index, final_state     valid & ready
//
// An encode runs the 32-step shift-subtract divider on the state, and when the state has to
// be renormalized the divider runs once more on the shifted state. A zero-frequency symbol
// gives an error result.
// Reset is synchronous and active low; the tables are not cleared and must be loaded first.
// A result sits in the output register until taken; the block accepts the next transaction
// meanwhile and stalls only when a second result is ready while the first still waits.
module rans_encoder_16bit_renorm import rans16_pkg::*; #(
  parameter int ALPHABET_SIZE = 32,
  parameter int TOTAL_FREQ    = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  rans16_in_if.sink    in_chan,
  rans16_out_if.source out_chan
);

  localparam int ADDR_W = $clog2(ALPHABET_SIZE);
  localparam int MULT_W = $clog2(TOTAL_FREQ + 1);
  localparam int PROD_W = STATE_W + MULT_W;
  localparam int SUM_W  = PROD_W + 1;

  enc_state_t         state_r, state_nxt;
  logic [STATE_W-1:0] coder_state_r, coder_state_nxt;
  logic [WORD_W-1:0]  word_count_r, word_count_nxt;
  logic               pass2_r, pass2_nxt;
  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic [CUM_W-1:0]   cum_r, cum_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [FREQ_W-1:0]  rem_r, rem_nxt;

  // Pending result, held until the output register is free.
  logic [KIND_W-1:0]  res_kind_r, res_kind_nxt;
  logic [WORD_W-1:0]  res_word_r, res_word_nxt;
  logic [WORD_W-1:0]  res_idx_r, res_idx_nxt;
  logic [STATE_W-1:0] res_fin_r, res_fin_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic [WORD_W-1:0]  out_idx_r, out_idx_nxt;
  logic [STATE_W-1:0] out_fin_r, out_fin_nxt;

  logic               in_acc;
  logic               sym_ok;
  logic [ADDR_W-1:0]  sym_addr;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [FREQ_W-1:0]  ram_freq;
  logic [CUM_W-1:0]   ram_cum;

  logic               div_start;
  logic               div_done;
  logic [STATE_W-1:0] div_dividend;
  logic [FREQ_W-1:0]  div_divisor;
  logic [STATE_W-1:0] div_quot;
  logic [FREQ_W-1:0]  div_rem;

  logic [SUM_W-1:0]   sum;
  logic               sum_ovf;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign sym_ok        = 32'(in_chan.symbol_index) < ALPHABET_SIZE;
  assign sym_addr      = ADDR_W'(in_chan.symbol_index);

  // Frequency and cumulative start share one table entry; the read address follows the
  // input so that the entry is ready the cycle after an encode is accepted.
  rans16_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sym_addr),
    .wdata ({in_chan.load_freq, in_chan.load_cum}),
    .raddr (sym_addr),
    .rdata (ram_rdata)
  );

  assign ram_freq = ram_rdata[ENTRY_W-1:CUM_W];
  assign ram_cum  = ram_rdata[CUM_W-1:0];

  // The first pass divides the full state; after a renormalization the upper half.
  assign div_dividend = (state_r == ST_FETCH) ? coder_state_r
                                              : {{WORD_W{1'b0}}, coder_state_r[STATE_W-1:WORD_W]};
  assign div_divisor  = (state_r == ST_FETCH) ? ram_freq : freq_r;

  rans16_div #(
    .DW (STATE_W),
    .VW (FREQ_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // The mapped value overflows when anything lands above the 32-bit state.
  assign sum     = SUM_W'(prod_r) + SUM_W'(cum_r) + SUM_W'(rem_r);
  assign sum_ovf = |sum[SUM_W-1:STATE_W];

  always_comb begin
    state_nxt       = state_r;
    coder_state_nxt = coder_state_r;
    word_count_nxt  = word_count_r;
    pass2_nxt       = pass2_r;
    freq_nxt        = freq_r;
    cum_nxt         = cum_r;
    prod_nxt        = prod_r;
    rem_nxt         = rem_r;
    res_kind_nxt    = res_kind_r;
    res_word_nxt    = res_word_r;
    res_idx_nxt     = res_idx_r;
    res_fin_nxt     = res_fin_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_kind_nxt    = out_kind_r;
    out_word_nxt    = out_word_r;
    out_idx_nxt     = out_idx_r;
    out_fin_nxt     = out_fin_r;
    ram_we          = 1'b0;
    div_start       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_chan.req_type)
            REQ_LOAD: begin
              ram_we = sym_ok;
            end
            REQ_ENCODE: begin
              pass2_nxt = 1'b0;
              if (sym_ok) begin
                state_nxt = ST_FETCH;
              end else begin
                res_kind_nxt = KIND_ERROR;
                res_word_nxt = '0;
                res_idx_nxt  = '0;
                res_fin_nxt  = '0;
                state_nxt    = ST_EMIT;
              end
            end
            REQ_FLUSH: begin
              res_kind_nxt    = KIND_FINAL;
              res_word_nxt    = '0;
              res_idx_nxt     = '0;
              res_fin_nxt     = coder_state_r;
              coder_state_nxt = STATE_RESET;
              word_count_nxt  = '0;
              state_nxt       = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (ram_freq == '0) begin
          res_kind_nxt = KIND_ERROR;
          res_word_nxt = '0;
          res_idx_nxt  = '0;
          res_fin_nxt  = '0;
          state_nxt    = ST_EMIT;
        end else begin
          freq_nxt  = ram_freq;
          cum_nxt   = ram_cum;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(div_quot) * PROD_W'(TOTAL_FREQ);
        rem_nxt   = div_rem;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sum_ovf && !pass2_r) begin
          // Shift out the low half of the state and map the rest again.
          res_kind_nxt   = KIND_WORD;
          res_word_nxt   = coder_state_r[WORD_W-1:0];
          res_idx_nxt    = word_count_r;
          res_fin_nxt    = '0;
          word_count_nxt = word_count_r + 1'b1;
          pass2_nxt      = 1'b1;
          div_start      = 1'b1;
          state_nxt      = ST_DIV;
        end else begin
          coder_state_nxt = sum[STATE_W-1:0];
          state_nxt       = pass2_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_word_nxt  = res_word_r;
          out_idx_nxt   = res_idx_r;
          out_fin_nxt   = res_fin_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      coder_state_r <= STATE_RESET;
      word_count_r  <= '0;
      pass2_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      coder_state_r <= coder_state_nxt;
      word_count_r  <= word_count_nxt;
      pass2_r       <= pass2_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    freq_r     <= freq_nxt;
    cum_r      <= cum_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    res_kind_r <= res_kind_nxt;
    res_word_r <= res_word_nxt;
    res_idx_r  <= res_idx_nxt;
    res_fin_r  <= res_fin_nxt;
    out_kind_r <= out_kind_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_kind    = out_kind_r;
  assign out_chan.renorm_word = out_word_r;
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.final_state = out_fin_r;

  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  // A flush restarts the coder at once.
  a_flush_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.req_type == REQ_FLUSH) |=>
      (coder_state_r == STATE_RESET && word_count_r == '0))
    else $error("flush did not restart the coder state");

  // A pending result reaches the output register once the slot is free.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && (!out_valid_r || out_chan.ready)) |=> out_valid_r)
    else $error("pending result was not moved to the output register");

  // The coder state only changes while an item is being worked on.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !in_acc) |=> $stable(coder_state_r))
    else $error("coder state changed while idle");

endmodule

@@ design/rans16_ram.sv @@
module rans16_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rans16_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rans16_div #(
  parameter int DW = 32,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quot_r, quot_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_r, quot_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DW-2:0], ge};
      rem_nxt  = ge ? VW'(rem_sh - {1'b0, dvs_r}) : VW'(rem_sh);
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

@@ bench/tb_rans_encoder_16bit_renorm.sv @@
`timescale 1ns / 1ps

// Testbench for the rANS encoder with 16-bit renormalization.
//
// The sender walks a short script of directed requests and then a long stream of random
// requests. Every accepted input transaction is fed to a local copy of the coder: it keeps
// its own state, word counter and symbol tables. Whatever result that copy produces is queued.
// A few script rows carry a hand-written result instead. Those are the values that are
// obvious at a glance, such as a flush straight after reset or a zero-frequency error.
// The output monitor pops the oldest queued result for each output transaction and compares
// it field by field.
module tb_rans_encoder_16bit_renorm;
  import rans16_pkg::*;

  localparam int ALPHABET      = 32;
  localparam int TOTAL         = 128;
  localparam int SCRIPT_LEN    = 25;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  // Request code that the block has to ignore.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [SYM_W-1:0]  sym;
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum;
  } coder_req_t;

  typedef struct packed {
    kind_e_t            kind;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  idx;
    logic [STATE_W-1:0] fin;
  } coder_out_t;

  typedef struct {
    coder_req_t rq;
    bit         known;
    coder_out_t want;
  } script_row_t;

  logic clk;
  logic rst_n;

  rans16_in_if  in_chan ();
  rans16_out_if out_chan ();

  rans_encoder_16bit_renorm #(
    .ALPHABET_SIZE(ALPHABET),
    .TOTAL_FREQ   (TOTAL)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Local copy of the coder.
  logic [STATE_W-1:0] coder_x;
  logic [WORD_W-1:0]  words_out;
  logic [FREQ_W-1:0]  freq_mem [ALPHABET];
  logic [CUM_W-1:0]   cum_mem  [ALPHABET];
  bit                 loaded   [ALPHABET];

  // Results still owed by the block, oldest first.
  coder_out_t results_owed [$];

  int  mismatches;
  int  cycles;
  // Set by the sender: calm turns idling off on both sides, and hold_request asks the
  // receiver for one long hold-off.
  bit  calm;
  bit  hold_request;

  script_row_t script [SCRIPT_LEN];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // One rANS state transition: (x / f) * M + c + x % f, kept wide enough to see overflow.
  function automatic logic [63:0] rans_map(input logic [63:0] x, input logic [63:0] f,
                                           input logic [63:0] c);
    return (x / f) * TOTAL + c + (x % f);
  endfunction

  // Applies one accepted request to the local coder and reports the result it causes, if any.
  task automatic rans_predict(input coder_req_t rq, output bit has_out,
                              output coder_out_t res);
    logic [63:0] x;
    logic [63:0] f;
    logic [63:0] c;
    logic [63:0] nx;
    has_out = 1'b0;
    res     = '0;
    case (rq.req)
      REQ_LOAD: begin
        // Every 5-bit index lies inside the alphabet, so a load is never ignored here.
        freq_mem[rq.sym] = rq.freq;
        cum_mem[rq.sym]  = rq.cum;
        loaded[rq.sym]   = 1'b1;
      end
      REQ_ENCODE: begin
        if (freq_mem[rq.sym] == '0) begin
          // A symbol with zero frequency cannot be coded; the state stays as it is.
          has_out  = 1'b1;
          res.kind = KIND_ERROR;
        end else begin
          f  = 64'(freq_mem[rq.sym]);
          c  = 64'(cum_mem[rq.sym]);
          x  = 64'(coder_x);
          nx = rans_map(x, f, c);
          if (nx > 64'hFFFF_FFFF) begin
            // Shift out the low word, then code the symbol again from the shifted state.
            has_out   = 1'b1;
            res.kind  = KIND_WORD;
            res.word  = x[WORD_W-1:0];
            res.idx   = words_out;
            words_out = words_out + 1'b1;
            x         = x >> WORD_W;
            nx        = rans_map(x, f, c);
          end
          coder_x = nx[STATE_W-1:0];
        end
      end
      REQ_FLUSH: begin
        has_out   = 1'b1;
        res.kind  = KIND_FINAL;
        res.fin   = coder_x;
        coder_x   = STATE_RESET;
        words_out = '0;
      end
      default: begin
        // Unused code: nothing changes.
      end
    endcase
  endtask

  function automatic script_row_t row(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                                      input logic [FREQ_W-1:0] freq,
                                      input logic [CUM_W-1:0] cum, input bit known,
                                      input kind_e_t kind, input logic [STATE_W-1:0] fin);
    script_row_t r;
    r.rq.req    = req;
    r.rq.sym    = sym;
    r.rq.freq   = freq;
    r.rq.cum    = cum;
    r.known     = known;
    r.want      = '0;
    r.want.kind = kind;
    r.want.fin  = fin;
    return r;
  endfunction

  // Drops valid for a random number of cycles. Most gaps are short; a few are long enough
  // to land in any phase of the divider.
  task automatic idle_gap();
    int n;
    n = 0;
    if (!calm) begin
      if ($urandom_range(99) < 5) begin
        n = $urandom_range(80, 1);
      end else begin
        while ($urandom_range(99) < 34) n++;
      end
    end
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one request and waits for its transaction. The result it causes is queued at the
  // edge of acceptance, either from the local coder or, for a known row, as written.
  task automatic send_request(input coder_req_t rq, input bit known, input coder_out_t want);
    bit         has_out;
    coder_out_t predicted;
    in_chan.valid        <= 1'b1;
    in_chan.req_type     <= rq.req;
    in_chan.symbol_index <= rq.sym;
    in_chan.load_freq    <= rq.freq;
    in_chan.load_cum     <= rq.cum;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    rans_predict(rq, has_out, predicted);
    if (known) begin
      results_owed.push_back(want);
    end else if (has_out) begin
      results_owed.push_back(predicted);
    end
  endtask

  // Sender: reset, directed script, then random traffic.
  initial begin
    coder_req_t rq;
    int         counted;
    int         r;
    int         s;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.req_type     <= REQ_LOAD;
    in_chan.symbol_index <= '0;
    in_chan.load_freq    <= '0;
    in_chan.load_cum     <= '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    mismatches   = 0;
    coder_x      = STATE_RESET;
    words_out    = '0;
    foreach (loaded[i]) begin
      loaded[i]   = 1'b0;
      freq_mem[i] = '0;
      cum_mem[i]  = '0;
    end

    // A flush straight after reset gives out the reset state.
    script[0]  = row(REQ_FLUSH,  5'd31, 8'd128, 7'd127, 1, KIND_FINAL, STATE_RESET);
    script[1]  = row(REQ_UNUSED, 5'd31, 8'd128, 7'd127, 0, KIND_WORD, '0);
    // Largest entry at the last index; one encode from reset lands on 65662.
    script[2]  = row(REQ_LOAD,   5'd31, 8'd128, 7'd127, 0, KIND_WORD, '0);
    script[3]  = row(REQ_ENCODE, 5'd31, 8'd0,   7'd0,   0, KIND_WORD, '0);
    script[4]  = row(REQ_FLUSH,  5'd0,  8'd0,   7'd0,   1, KIND_FINAL, 32'd65662);
    script[5]  = row(REQ_LOAD,   5'd0,  8'd1,   7'd0,   0, KIND_WORD, '0);
    // A zero-frequency entry must give the error result.
    script[6]  = row(REQ_LOAD,   5'd5,  8'd0,   7'd127, 0, KIND_WORD, '0);
    script[7]  = row(REQ_ENCODE, 5'd5,  8'd128, 7'd127, 1, KIND_ERROR, '0);
    script[8]  = row(REQ_LOAD,   5'd10, 8'd2,   7'd1,   0, KIND_WORD, '0);
    script[9]  = row(REQ_LOAD,   5'd21, 8'd4,   7'd85,  0, KIND_WORD, '0);
    // Frequency one multiplies the state by 128, so the third of these overflows.
    script[10] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[11] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[12] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[13] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[14] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[15] = row(REQ_ENCODE, 5'd10, 8'd0,   7'd0,   0, KIND_WORD, '0);
    script[16] = row(REQ_ENCODE, 5'd21, 8'd0,   7'd0,   0, KIND_WORD, '0);
    script[17] = row(REQ_ENCODE, 5'd31, 8'd0,   7'd0,   0, KIND_WORD, '0);
    script[18] = row(REQ_UNUSED, 5'd0,  8'd1,   7'd0,   0, KIND_WORD, '0);
    script[19] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[20] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[21] = row(REQ_FLUSH,  5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    // Reload an entry. With f = 128 and c = 0 the state maps onto itself, so the flush gives
    // out the reset state again.
    script[22] = row(REQ_LOAD,   5'd0,  8'd128, 7'd0,   0, KIND_WORD, '0);
    script[23] = row(REQ_ENCODE, 5'd0,  8'd0,   7'd0,   0, KIND_WORD, '0);
    script[24] = row(REQ_FLUSH,  5'd0,  8'd0,   7'd0,   1, KIND_FINAL, STATE_RESET);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      idle_gap();
      send_request(script[i].rq, script[i].known, script[i].want);
    end

    // Random traffic. It is mostly encodes of loaded symbols, so that the state grows
    // long enough to renormalize. Loads, flushes and unused codes are mixed in.
    // Unused codes do not count toward the item total.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      calm = (counted >= 600 && counted < 900);
      if (counted == 300) hold_request = 1'b1;
      if (counted == 1000) begin
        // Pause until the block has handed over everything it owes.
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (results_owed.size() != 0) @(posedge clk);
      end

      rq.sym  = 5'($urandom_range(ALPHABET - 1));
      rq.freq = 8'($urandom_range(TOTAL));
      rq.cum  = 7'($urandom_range(127));
      r = $urandom_range(99);
      if (r < 8) begin
        rq.req = REQ_LOAD;
        s = $urandom_range(99);
        // Small frequencies grow the state fast; zero and the maximum are kept in play.
        if (s < 35) rq.freq = 8'($urandom_range(3, 1));
        else if (s < 45) rq.freq = '0;
        else if (s < 50) rq.freq = 8'(TOTAL);
        else rq.freq = 8'($urandom_range(TOTAL, 1));
      end else if (r < 12) begin
        rq.req = REQ_FLUSH;
      end else if (r < 14) begin
        rq.req = REQ_UNUSED;
      end else begin
        rq.req = REQ_ENCODE;
        // Only entries that have been written are ever encoded.
        do s = $urandom_range(ALPHABET - 1); while (!loaded[s]);
        rq.sym = 5'(s);
      end
      idle_gap();
      send_request(rq, 1'b0, '0);
      if (rq.req != REQ_UNUSED) counted++;
    end
    calm = 1'b0;

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random backpressure, a calm stretch, and one long hold-off that fills the
  // block's output register and stalls its input.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (calm) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 34);
      end
    end
  end

  // Output monitor: every result transaction is matched against the oldest owed result.
  always @(posedge clk) begin
    coder_out_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (results_owed.size() == 0) begin
        flag_error($sformatf("unexpected result, kind %0d", out_chan.out_kind));
      end else begin
        want = results_owed.pop_front();
        check_field("out_kind", 32'(out_chan.out_kind), 32'(want.kind));
        check_field("renorm_word", 32'(out_chan.renorm_word), 32'(want.word));
        check_field("word_index", 32'(out_chan.word_index), 32'(want.idx));
        check_field("final_state", out_chan.final_state, want.fin);
      end
    end
  end

  // Watchdog: a lost result or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", results_owed.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
